>>> design/urlds_pkg.sv
// Shared constants and types for the URL path dot-segment removal block.
`default_nettype none
package urlds_pkg;

    localparam int MAX_PATH_DEF = 64;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam int WIN = 4;

    typedef logic [7:0] t_byte;
    typedef t_byte t_window [0:WIN-1];

    typedef struct packed {
        logic       done;
        logic [1:0] adv;
        logic       repl;
        logic       emit;
        logic       pop;
        logic       copy_nxt;
    } t_action;

endpackage
`default_nettype wire

>>> design/url_path_dot_segment_removal_top.sv
// Top level: path byte store, rule sequencer, segment pop walker and result emitter.
// After the last input beat the scan refills the four-byte window from the byte store,
// with a read and a load per byte, then decodes a rule step and checks the window again;
// a parent-segment pop walks back over emitted bytes up to a slash. Each result beat is
// read, loaded and held until the sink is ready; no new path is taken until the last is.
// Reset: synchronous active low; clears the sequencer, counts and flags, stores keep data.
`default_nettype none
module url_path_dot_segment_removal_top import urlds_pkg::*; #(
    parameter int MAX_PATH = MAX_PATH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_path_byte,
    input  wire logic       i_last_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_has_byte,
    output logic            o_out_last,
    output logic            o_overflowed
);

    localparam int AW = $clog2(MAX_PATH);
    localparam int CW = $clog2(MAX_PATH + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PATH);

    localparam logic [3:0] ST_LOAD   = 4'd0;
    localparam logic [3:0] ST_FILL   = 4'd1;
    localparam logic [3:0] ST_FDATA  = 4'd2;
    localparam logic [3:0] ST_STEP   = 4'd3;
    localparam logic [3:0] ST_POPRD  = 4'd4;
    localparam logic [3:0] ST_POPCHK = 4'd5;
    localparam logic [3:0] ST_EMRD   = 4'd6;
    localparam logic [3:0] ST_EMLD   = 4'd7;
    localparam logic [3:0] ST_EMWAIT = 4'd8;

    t_byte in_mem  [0:MAX_PATH-1];
    t_byte out_mem [0:MAX_PATH-1];
    t_byte r_in_rd, r_out_rd;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic          r_term, n_term;
    logic [CW-1:0] r_rp, n_rp;
    logic [2:0]    r_wn, n_wn;
    logic [CW-1:0] r_o, n_o;
    logic [CW-1:0] r_emk, n_emk;
    logic          r_copy, n_copy;
    logic          r_out_valid, n_out_valid;

    t_window       r_win, n_win;
    t_byte         r_out_byte, n_out_byte;
    logic          r_has_byte, n_has_byte;
    logic          r_out_last, n_out_last;

    t_window       cur_win;
    t_action       act;
    logic          in_acc, in_wr;
    logic [CW-1:0] out_raddr;

    assign o_ready      = (r_state == ST_LOAD);
    assign o_valid      = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_has_byte   = r_has_byte;
    assign o_out_last   = r_out_last;
    assign o_overflowed = r_ovf;

    assign in_acc = i_valid && o_ready;
    assign in_wr  = in_acc && !r_term && (i_path_byte != CH_NUL) && (r_cnt < MAX_CNT);

    always_comb begin
        for (int j = 0; j < WIN; j++) begin
            cur_win[j] = (3'(j) < r_wn) ? r_win[j] : CH_NUL;
        end
    end

    urlds_rule u_rule (
        .i_win  (cur_win),
        .i_copy (r_copy),
        .o_act  (act)
    );

    assign out_raddr = (r_state == ST_POPRD) ? (r_o - 1'b1) : r_emk;

    always_ff @(posedge i_clk) begin
        if (in_wr) begin
            in_mem[r_cnt[AW-1:0]] <= i_path_byte;
        end
        if (r_state == ST_FILL) begin
            r_in_rd <= in_mem[r_rp[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_STEP && !act.done && act.emit) begin
            out_mem[r_o[AW-1:0]] <= cur_win[0];
        end
        if ((r_state == ST_POPRD && r_o != '0) || r_state == ST_EMRD) begin
            r_out_rd <= out_mem[out_raddr[AW-1:0]];
        end
    end

    always_comb begin
        logic [2:0] s;
        s           = '0;
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_term      = r_term;
        n_rp        = r_rp;
        n_wn        = r_wn;
        n_o         = r_o;
        n_emk       = r_emk;
        n_copy      = r_copy;
        n_out_valid = r_out_valid;
        n_win       = r_win;
        n_out_byte  = r_out_byte;
        n_has_byte  = r_has_byte;
        n_out_last  = r_out_last;
        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (!r_term) begin
                        if (i_path_byte == CH_NUL) begin
                            n_term = 1'b1;
                        end else if (r_cnt < MAX_CNT) begin
                            n_cnt = r_cnt + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (i_last_byte) begin
                        n_rp    = '0;
                        n_wn    = '0;
                        n_o     = '0;
                        n_copy  = 1'b0;
                        n_state = ST_FILL;
                    end
                end
            end
            ST_FILL: begin
                if (r_wn == 3'(WIN) || r_rp == r_cnt) begin
                    n_state = ST_STEP;
                end else begin
                    n_rp    = r_rp + 1'b1;
                    n_state = ST_FDATA;
                end
            end
            ST_FDATA: begin
                n_win[r_wn[1:0]] = r_in_rd;
                n_wn             = r_wn + 3'd1;
                n_state          = ST_FILL;
            end
            ST_STEP: begin
                if (act.done) begin
                    n_emk   = '0;
                    n_state = ST_EMRD;
                end else begin
                    for (int j = 0; j < WIN; j++) begin
                        s        = 3'(j) + {1'b0, act.adv};
                        n_win[j] = (s < 3'(WIN)) ? r_win[s[1:0]] : CH_NUL;
                    end
                    if (act.repl) begin
                        n_win[0] = CH_SLASH;
                    end
                    n_wn   = r_wn - {1'b0, act.adv};
                    n_copy = act.copy_nxt;
                    if (act.emit) begin
                        n_o = r_o + 1'b1;
                    end
                    n_state = act.pop ? ST_POPRD : ST_FILL;
                end
            end
            ST_POPRD: begin
                n_state = (r_o == '0) ? ST_FILL : ST_POPCHK;
            end
            ST_POPCHK: begin
                n_o     = r_o - 1'b1;
                n_state = (r_out_rd == CH_SLASH) ? ST_FILL : ST_POPRD;
            end
            ST_EMRD: begin
                if (r_o == '0) begin
                    n_out_byte  = CH_NUL;
                    n_has_byte  = 1'b0;
                    n_out_last  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_EMWAIT;
                end else begin
                    n_state = ST_EMLD;
                end
            end
            ST_EMLD: begin
                n_out_byte  = r_out_rd;
                n_has_byte  = 1'b1;
                n_out_last  = ((r_emk + 1'b1) == r_o);
                n_out_valid = 1'b1;
                n_state     = ST_EMWAIT;
            end
            ST_EMWAIT: begin
                if (i_ready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_cnt   = '0;
                        n_ovf   = 1'b0;
                        n_term  = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_emk   = r_emk + 1'b1;
                        n_state = ST_EMRD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_term      <= 1'b0;
            r_rp        <= '0;
            r_wn        <= '0;
            r_o         <= '0;
            r_emk       <= '0;
            r_copy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_term      <= n_term;
            r_rp        <= n_rp;
            r_wn        <= n_wn;
            r_o         <= n_o;
            r_emk       <= n_emk;
            r_copy      <= n_copy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win      <= n_win;
        r_out_byte <= n_out_byte;
        r_has_byte <= n_has_byte;
        r_out_last <= n_out_last;
    end

endmodule
`default_nettype wire

>>> design/urlds_rule.sv
// Rule decoder: picks the dot-segment rule for the current four-byte window.
`default_nettype none
module urlds_rule import urlds_pkg::*; (
    input  t_window i_win,
    input  logic    i_copy,
    output t_action o_act
);

    t_byte c0, c1, c2, c3;

    assign c0 = i_win[0];
    assign c1 = i_win[1];
    assign c2 = i_win[2];
    assign c3 = i_win[3];

    always_comb begin
        o_act = '0;
        if (c0 == CH_NUL) begin
            o_act.done = 1'b1;
        end else if (i_copy) begin
            if (c0 == CH_SLASH) begin
                o_act.copy_nxt = 1'b0;
            end else begin
                o_act.emit     = 1'b1;
                o_act.adv      = 2'd1;
                o_act.copy_nxt = 1'b1;
            end
        end else if (c0 == CH_DOT && c1 == CH_DOT && c2 == CH_SLASH) begin
            o_act.adv = 2'd3;
        end else if (c0 == CH_DOT && c1 == CH_SLASH) begin
            o_act.adv = 2'd2;
        end else if (c0 == CH_SLASH && c1 == CH_DOT && c2 == CH_SLASH) begin
            o_act.adv = 2'd2;
        end else if (c0 == CH_SLASH && c1 == CH_DOT && c2 == CH_NUL) begin
            o_act.adv  = 2'd1;
            o_act.repl = 1'b1;
        end else if (c0 == CH_SLASH && c1 == CH_DOT && c2 == CH_DOT && c3 == CH_SLASH) begin
            o_act.adv = 2'd3;
            o_act.pop = 1'b1;
        end else if (c0 == CH_SLASH && c1 == CH_DOT && c2 == CH_DOT && c3 == CH_NUL) begin
            o_act.adv  = 2'd2;
            o_act.repl = 1'b1;
            o_act.pop  = 1'b1;
        end else if (c0 == CH_DOT && c1 == CH_NUL) begin
            o_act.adv = 2'd1;
        end else if (c0 == CH_DOT && c1 == CH_DOT && c2 == CH_NUL) begin
            o_act.adv = 2'd2;
        end else begin
            o_act.copy_nxt = 1'b1;
            if (c0 == CH_SLASH) begin
                o_act.emit = 1'b1;
                o_act.adv  = 2'd1;
            end
        end
    end

endmodule
`default_nettype wire
